### rtl/core/ndps_pkg.sv
// ----------------------------------------------------------------------------
// ndps_pkg: shared types, widths and sigmoid table builder
// Holds the product queue entry type, the datapath widths and the
// elaboration-time functions that build the sigmoid lookup table.
// ----------------------------------------------------------------------------
`default_nettype none

package ndps_pkg;

	// Datapath widths
	localparam int DATA_W    = 16;
	localparam int PROD_W    = 32;
	localparam int ACC_W     = 40;
	localparam int SHIFT     = 21;
	localparam int IDX_W     = ACC_W - SHIFT;
	localparam int ADDR_W    = 9;
	localparam int ROM_HALF  = 256;
	localparam int HALF_W    = 8;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 16;

	// Default depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Queue entry: one product and its end-of-fan-in flag
	typedef struct packed {
		logic signed [PROD_W-1:0] prod;
		logic                     last;
	} entry_t;

	// Q62 constants
	localparam logic [63:0] Q62_ONE  = 64'h4000_0000_0000_0000;
	localparam logic [63:0] Q63_ONE  = 64'h8000_0000_0000_0000;
	localparam logic [63:0] Q31_ONE  = 64'h0000_0000_8000_0000;
	localparam logic [63:0] RND_HALF = 64'h0000_0000_0000_4000;
	localparam logic [63:0] SAT_MAX  = 64'h0000_0000_0000_FFFF;

	// Restoring shift-subtract divide, used at elaboration only
	function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// (a * b) >> 62 for Q62 operands
	function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
		logic [127:0] t;
		t = {64'd0, a} * {64'd0, b};
		return t[125:62];
	endfunction

	// Sigmoid table entry at address idx (table index k = idx - 256)
	function automatic logic [DATA_W-1:0] sig_entry(int unsigned idx);
		logic [63:0] r;
		logic [63:0] term;
		logic [63:0] r2;
		logic [63:0] p;
		logic [63:0] den;
		logic [63:0] q;
		logic [63:0] val;
		int unsigned steps;
		r    = Q62_ONE;
		term = Q62_ONE;
		// exp(-1/64) by its Taylor series
		for (int n = 1; n <= 20; n++) begin
			term = udiv64(term, 64'(64 * n));
			if (n % 2 == 1) begin
				r = r - term;
			end else begin
				r = r + term;
			end
		end
		r2    = mul_q62(r, r);
		p     = r;
		steps = (idx >= ROM_HALF) ? idx - ROM_HALF : (ROM_HALF - 1) - idx;
		for (int unsigned k = 0; k < steps; k++) begin
			p = mul_q62(p, r2);
		end
		den = (Q62_ONE + p) >> 30;
		q   = udiv64(Q63_ONE, den);
		if (idx >= ROM_HALF) begin
			val = (q + RND_HALF) >> 15;
		end else begin
			val = ((Q31_ONE - q) + RND_HALF) >> 15;
		end
		if (val > SAT_MAX) begin
			val = SAT_MAX;
		end
		return val[DATA_W-1:0];
	endfunction

endpackage

`default_nettype wire

### rtl/core/ndps_front.sv
// ----------------------------------------------------------------------------
// ndps_front: input stage and multiplier
// Accepts activation/weight requests, registers their signed product with
// the last flag and hands it to the product queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ndps_front (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic signed [ndps_pkg::DATA_W-1:0]   activation,
	input  wire logic signed [ndps_pkg::DATA_W-1:0]   weight,
	input  wire logic                                 last,
	output logic                                      push_valid,
	input  wire logic                                 push_ready,
	output ndps_pkg::entry_t                          push_data
);

	logic              valid_s1;
	ndps_pkg::entry_t  entry_s1;
	logic              take;

	// Take a request when the stage is empty or drains this cycle
	assign in_ready = !valid_s1 || push_ready;
	assign take     = in_valid && in_ready;

	// Hold stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Register product and flag
	always_ff @(posedge clk) begin
		if (take) begin
			entry_s1.prod <= ndps_pkg::PROD_W'(activation) * ndps_pkg::PROD_W'(weight);
			entry_s1.last <= last;
		end
	end

	assign push_valid = valid_s1;
	assign push_data  = entry_s1;

endmodule

`default_nettype wire

### rtl/core/ndps_queue.sv
// ----------------------------------------------------------------------------
// ndps_queue: short product queue
// Register-based FIFO between front and back so that each side can stall
// on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module ndps_queue #(
	parameter int DEPTH = ndps_pkg::QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_valid,
	output logic                   push_ready,
	input  wire ndps_pkg::entry_t  push_data,
	output logic                   pop_valid,
	input  wire logic              pop_ready,
	output ndps_pkg::entry_t       pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ndps_pkg::entry_t  mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue fill count beyond depth");

	a_count_push: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count missed a push");

endmodule

`default_nettype wire

### rtl/core/ndps_back.sv
// ----------------------------------------------------------------------------
// ndps_back: accumulator, index clamp and sigmoid lookup
// Pops products, accumulates them in 40 bits and, at the end of a fan-in,
// turns the sum into a table address and emits the sigmoid value.
// ----------------------------------------------------------------------------
`default_nettype none

module ndps_back (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               pop_valid,
	output logic                                    pop_ready,
	input  wire ndps_pkg::entry_t                   pop_data,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [ndps_pkg::DATA_W-1:0]             neuron_out
);

	logic                                   adv;
	logic signed [ndps_pkg::ACC_W-1:0]      acc_q;
	logic signed [ndps_pkg::ACC_W-1:0]      acc_next;
	logic                                   valid_s1;
	logic signed [ndps_pkg::ACC_W-1:0]      sum_s1;
	logic signed [ndps_pkg::IDX_W-1:0]      idx;
	logic [ndps_pkg::ADDR_W-1:0]            addr;
	logic                                   valid_s2;
	logic [ndps_pkg::ADDR_W-1:0]            addr_s2;
	logic                                   out_valid_q;
	logic [ndps_pkg::DATA_W-1:0]            out_data_q;
	logic [ndps_pkg::DATA_W-1:0]            rom_lo [ndps_pkg::ROM_HALF];
	logic [ndps_pkg::DATA_W-1:0]            rom_hi [ndps_pkg::ROM_HALF];

	// Advance the whole back pipeline when the output register frees up
	assign adv       = !out_valid_q || out_ready;
	assign pop_ready = adv;
	assign acc_next  = acc_q + ndps_pkg::ACC_W'(pop_data.prod);

	// Accumulate; clear at the end of a fan-in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (adv && pop_valid) begin
			acc_q <= pop_data.last ? '0 : acc_next;
		end
	end

	// Valid bits of the back pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= pop_valid && pop_data.last;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	// Floor shift and clamp to -256..255, then offset by 256
	assign idx = sum_s1[ndps_pkg::ACC_W-1:ndps_pkg::SHIFT];
	always_comb begin
		if (idx[ndps_pkg::IDX_W-1] && (idx[ndps_pkg::IDX_W-2:ndps_pkg::HALF_W] != '1)) begin
			addr = '0;
		end else if (!idx[ndps_pkg::IDX_W-1] &&
				(idx[ndps_pkg::IDX_W-2:ndps_pkg::HALF_W] != '0)) begin
			addr = '1;
		end else begin
			addr = {~idx[ndps_pkg::HALF_W], idx[ndps_pkg::HALF_W-1:0]};
		end
	end

	// Sigmoid table, split in two halves
	for (genvar g = 0; g < ndps_pkg::ROM_HALF; g++) begin : g_rom
		localparam logic [ndps_pkg::DATA_W-1:0] LO = ndps_pkg::sig_entry(g);
		localparam logic [ndps_pkg::DATA_W-1:0] HI =
			ndps_pkg::sig_entry(g + ndps_pkg::ROM_HALF);
		assign rom_lo[g] = LO;
		assign rom_hi[g] = HI;
	end

	// Payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s1     <= acc_next;
			addr_s2    <= addr;
			out_data_q <= addr_s2[ndps_pkg::ADDR_W-1] ?
				rom_hi[addr_s2[ndps_pkg::HALF_W-1:0]] :
				rom_lo[addr_s2[ndps_pkg::HALF_W-1:0]];
		end
	end

	assign out_valid  = out_valid_q;
	assign neuron_out = out_data_q;

	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && pop_valid && pop_data.last) |=> acc_q == '0)
		else $error("accumulator not cleared after end of fan-in");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s2))
		else $error("result raised without a lookup in flight");

endmodule

`default_nettype wire

### rtl/core/neuron_dot_product_sigmoid_top.sv
// ----------------------------------------------------------------------------
// neuron_dot_product_sigmoid_top: single neuron, dot product and sigmoid
// Usage:
//   Input stream (s_*): one request per activation/weight pair; s_tdata
//   carries activation in [15:0] and weight in [31:16], both signed, and
//   s_tlast marks the final pair of the neuron's fan-in.
//   Output stream (m_*): one result per fan-in, m_tdata[15:0] is the
//   sigmoid of the weighted sum, unsigned Q0.16.
// Throughput: one pair per clock while no stall holds the flow; the multiplier
//   and the accumulator each take one pair per cycle.
// Path: the request that carries s_tlast passes the multiply, queue, accumulate,
//   clamp and lookup registers before its result shows on m_tvalid.
// Stalls: a low m_tready holds the result register and the back pipeline;
//   the front keeps taking requests until the product queue (QUEUE_DEPTH
//   entries) and the multiplier stage fill, then drops s_tready.
// Reset: arst_n clears the accumulator, the queue and all valid bits; the
//   block takes requests in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module neuron_dot_product_sigmoid_top #(
	parameter int QUEUE_DEPTH = ndps_pkg::QUEUE_DEPTH
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [ndps_pkg::IN_TDATA_W-1:0]      s_tdata,  // activation, weight
	input  wire logic                                 s_tlast,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic [ndps_pkg::OUT_TDATA_W-1:0]          m_tdata   // neuron_out
);

	logic              push_valid;
	logic              push_ready;
	ndps_pkg::entry_t  push_data;
	logic              pop_valid;
	logic              pop_ready;
	ndps_pkg::entry_t  pop_data;
	logic [ndps_pkg::DATA_W-1:0] neuron_out;

	// Accept and multiply
	ndps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.activation (s_tdata[ndps_pkg::DATA_W-1:0]),
		.weight     (s_tdata[2*ndps_pkg::DATA_W-1:ndps_pkg::DATA_W]),
		.last       (s_tlast),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// Decouple front from back
	ndps_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// Accumulate and look up the sigmoid
	ndps_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.neuron_out (neuron_out)
	);

	assign m_tdata = neuron_out;

endmodule

`default_nettype wire

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stream testbench for the dot product and sigmoid neuron
// Drives activation/weight pairs in directed and random-length fan-ins, predicts each
// sigmoid output from a private copy of the accumulator and the lookup table,
// and compares every output request in order. Both sides idle at random; the
// receiver stalls once for a long stretch so the block fills and backs up.
// ----------------------------------------------------------------------------

module tb_top;

	localparam int DATA_W      = ndps_pkg::DATA_W;
	localparam int PROD_W      = ndps_pkg::PROD_W;
	localparam int ACC_W       = ndps_pkg::ACC_W;
	localparam int SHIFT       = ndps_pkg::SHIFT;
	localparam int IN_TDATA_W  = ndps_pkg::IN_TDATA_W;
	localparam int OUT_TDATA_W = ndps_pkg::OUT_TDATA_W;

	localparam int ROM_SIZE    = 512;
	localparam int IDX_MIN     = -256;
	localparam int IDX_MAX     = 255;
	localparam int IDLE_PCT    = 26;
	localparam int RANDOM_PAIRS = 110;
	localparam int HOLD_CYCLES = 120;
	localparam int DRAIN_CYCLES = 20;

	// Scoreboard: neuron predictor plus the queue of expected sigmoid outputs
	class neuron_scoreboard;
		logic [DATA_W-1:0]        sigmoid_rom [ROM_SIZE];
		logic signed [ACC_W-1:0]  dot_sum;
		logic [DATA_W-1:0]        expected_outputs [$];
		int                       failures;
		int                       outputs_checked;
		int                       pairs_seen;
		int                       fanins_seen;

		function new();
			dot_sum         = '0;
			failures        = 0;
			outputs_checked = 0;
			pairs_seen      = 0;
			fanins_seen     = 0;
			fill_sigmoid_rom();
		endfunction

		// Q62 product, keep bits 125..62 of the full 128-bit result
		function longint unsigned q62_times(longint unsigned a, longint unsigned b);
			logic [127:0] wide;
			wide = 128'(a) * 128'(b);
			return 64'(wide >> 62);
		endfunction

		// Build the table with integer math: exp(-1/64) by series, then odd powers
		function void fill_sigmoid_rom();
			longint unsigned e_step;
			longint unsigned term;
			longint unsigned e_sq;
			longint unsigned e_pow;
			longint unsigned den;
			longint unsigned quot;
			longint unsigned upper;
			longint unsigned lower;
			e_step = 64'h4000_0000_0000_0000;
			term   = 64'h4000_0000_0000_0000;
			for (int n = 1; n <= 20; n++) begin
				term = term / longint'(64 * n);
				if (n % 2 == 1) begin
					e_step = e_step - term;
				end else begin
					e_step = e_step + term;
				end
			end
			e_sq  = q62_times(e_step, e_step);
			e_pow = e_step;
			for (int k = 0; k < ROM_SIZE / 2; k++) begin
				den   = (64'h4000_0000_0000_0000 + e_pow) >> 30;
				quot  = 64'h8000_0000_0000_0000 / den;
				upper = (quot + 64'h4000) >> 15;
				lower = ((64'h8000_0000 - quot) + 64'h4000) >> 15;
				if (upper > 64'hFFFF) begin
					upper = 64'hFFFF;
				end
				if (lower > 64'hFFFF) begin
					lower = 64'hFFFF;
				end
				sigmoid_rom[ROM_SIZE / 2 + k]     = upper[DATA_W-1:0];
				sigmoid_rom[ROM_SIZE / 2 - 1 - k] = lower[DATA_W-1:0];
				e_pow = q62_times(e_pow, e_sq);
			end
		endfunction

		// Accumulate one accepted pair; on last, queue the sigmoid and clear
		function void note_pair(logic signed [DATA_W-1:0] act,
				logic signed [DATA_W-1:0] wt, logic last);
			logic signed [PROD_W-1:0]      product;
			logic signed [ACC_W-SHIFT-1:0] index;
			int                            addr;
			product = PROD_W'(act) * PROD_W'(wt);
			dot_sum = dot_sum + ACC_W'(product);
			pairs_seen++;
			if (last) begin
				index = dot_sum[ACC_W-1:SHIFT];
				if (index < IDX_MIN) begin
					addr = 0;
				end else if (index > IDX_MAX) begin
					addr = ROM_SIZE - 1;
				end else begin
					addr = int'(index) + ROM_SIZE / 2;
				end
				expected_outputs = {expected_outputs, sigmoid_rom[addr]};
				dot_sum = '0;
				fanins_seen++;
			end
		endfunction

		// Compare one output request with the oldest expectation
		function void check_output(logic [DATA_W-1:0] actual);
			logic [DATA_W-1:0] expected;
			if (expected_outputs.size() == 0) begin
				$display("%0t: unexpected neuron_out, expected none, actual %0d",
					$time, actual);
				failures++;
				return;
			end
			expected = expected_outputs.pop_front();
			outputs_checked++;
			if (actual !== expected) begin
				$display("%0t: neuron_out mismatch, expected %0d, actual %0d",
					$time, expected, actual);
				failures++;
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [IN_TDATA_W-1:0]    s_tdata;
	logic                     s_tlast;
	logic                     m_tvalid;
	logic                     m_tready;
	logic [OUT_TDATA_W-1:0]   m_tdata;

	neuron_scoreboard sb = new();
	bit               steady_phase = 1'b0;
	bit               stimulus_done = 1'b0;

	neuron_dot_product_sigmoid_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // activation, weight
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)    // neuron_out
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Idle roll shared by both sides; none while the steady phase runs
	function automatic bit idle_now();
		return !steady_phase && ($urandom_range(0, 99) < IDLE_PCT);
	endfunction

	// Offer one pair at the falling edge and wait for the request to go through
	task automatic send_pair(logic signed [DATA_W-1:0] act,
			logic signed [DATA_W-1:0] wt, logic last);
		while (idle_now()) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {wt, act};
		s_tlast  <= last;
		do begin
			@(posedge clk);
		end while (!s_tready);
		sb.note_pair(act, wt, last);
		@(negedge clk);
	endtask

	// Operand mix: full random, scaled magnitudes of at most 2**14, extremes
	function automatic logic signed [DATA_W-1:0] pick_operand();
		int mode;
		int bits;
		mode = $urandom_range(0, 99);
		if (mode < 30) begin
			return DATA_W'($urandom);
		end else if (mode < 85) begin
			bits = $urandom_range(1, 14);
			return DATA_W'($signed($urandom_range(0, (1 << (bits + 1)) - 1)) - (1 << bits));
		end else begin
			case ($urandom_range(0, 4))
				0: return 16'sh8000;
				1: return 16'sh7FFF;
				2: return 16'sh0000;
				3: return -16'sd1;
				default: return 16'sd1;
			endcase
		end
	endfunction

	// Receiver: random ready, one long hold-off once traffic is flowing
	initial begin
		bit held;
		held = 1'b0;
		m_tready = 1'b1;
		forever begin
			@(negedge clk);
			if (!held && sb.outputs_checked >= 10) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= !idle_now();
			end
		end
	end

	// Check every output request at the rising edge
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_output(m_tdata);
		end
	end

	// Run limit
	initial begin
		#400000;
		$display("Simulation FAILED");
		$finish;
	end

	// Stimulus
	initial begin
		int random_pairs;
		int fanin_len;
		int roll;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		arst_n   = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Zero sum, both saturations and the largest product
		send_pair(16'sd0, 16'sd0, 1'b1);
		send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
		send_pair(16'sh8000, 16'sh7FFF, 1'b1);
		send_pair(16'sh8000, 16'sh8000, 1'b1);
		// Floor rounding around zero and around one index step
		send_pair(16'sd1, -16'sd1, 1'b1);
		send_pair(16'sd16384, 16'sd128, 1'b1);
		send_pair(16'sd16384, 16'sd128, 1'b0);
		send_pair(16'sd1, -16'sd1, 1'b1);
		send_pair(-16'sd16384, 16'sd128, 1'b1);
		send_pair(-16'sd16384, 16'sd128, 1'b0);
		send_pair(16'sd1, -16'sd1, 1'b1);
		// Table edges: exactly 255 and -256, then one past each
		send_pair(16'sd16384, 16'sd32640, 1'b1);
		send_pair(16'sd16384, 16'sd32640, 1'b0);
		send_pair(16'sd16384, 16'sd128, 1'b1);
		send_pair(16'sd16384, 16'sh8000, 1'b1);
		send_pair(16'sd16384, 16'sh8000, 1'b0);
		send_pair(16'sd1, -16'sd1, 1'b1);
		// Alternating bit patterns in a short fan-in
		send_pair(16'sh5555, 16'shAAAA, 1'b0);
		send_pair(16'shAAAA, 16'sh5555, 1'b0);
		send_pair(16'sh00FF, 16'shFF00, 1'b1);

		// Overlong fan-in of full-scale products passes the full fan-in and
		// wraps the accumulator into the negative range
		for (int i = 0; i < 520; i++) begin
			send_pair(16'sh8000, 16'sh8000, i == 519);
		end

		// Random fan-ins, mostly short, with a no-idle stretch in the middle
		random_pairs = 0;
		while (random_pairs < RANDOM_PAIRS) begin
			roll = $urandom_range(0, 99);
			if (roll < 60) begin
				fanin_len = $urandom_range(1, 4);
			end else if (roll < 90) begin
				fanin_len = $urandom_range(5, 20);
			end else if (roll < 98) begin
				fanin_len = $urandom_range(21, 64);
			end else begin
				fanin_len = $urandom_range(200, 256);
			end
			if (fanin_len > RANDOM_PAIRS - random_pairs) begin
				fanin_len = RANDOM_PAIRS - random_pairs;
			end
			for (int i = 0; i < fanin_len; i++) begin
				steady_phase = (random_pairs >= 30) && (random_pairs < 80);
				send_pair(pick_operand(), pick_operand(), i == fanin_len - 1);
				random_pairs++;
			end
		end
		steady_phase = 1'b0;
		s_tvalid <= 1'b0;

		// Drain, then allow for the pipeline latency
		while (sb.expected_outputs.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d pairs in %0d fan-ins, including a wrapping fan-in",
			sb.pairs_seen, sb.fanins_seen);
		$display("%0d outputs checked, %0d failures", sb.outputs_checked, sb.failures);
		if (sb.failures == 0 && sb.expected_outputs.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

### files.f
rtl/core/ndps_pkg.sv
rtl/core/ndps_front.sv
rtl/core/ndps_queue.sv
rtl/core/ndps_back.sv
rtl/core/neuron_dot_product_sigmoid_top.sv
test/tb_top.sv
